FILE: hw/rtl/pfm_pkg.sv
package pfm_pkg;

	// operation codes
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_CHECK  = 2'd2;

	// rate classes
	localparam logic [1:0] CLASS_OK   = 2'd0;
	localparam logic [1:0] CLASS_SLOW = 2'd1;
	localparam logic [1:0] CLASS_FAST = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_CONSTANT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSES    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_TIMEOUT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_THRESH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_THRESH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_GAL = 3'd5;
	localparam int CFG_DATA_W = 24;

	// configuration reset values
	localparam logic [19:0] RST_RATE_CONSTANT = 20'd36065;
	localparam logic [7:0]  RST_MIN_PULSES    = 8'd3;
	localparam logic [15:0] RST_PULSE_TIMEOUT = 16'd1000;
	localparam logic [23:0] RST_SLOW_THRESH   = 24'd256;
	localparam logic [23:0] RST_FAST_THRESH   = 24'd4096;
	localparam logic [19:0] RST_PULSES_PER_GAL = 20'd309818;

	// divider geometry: 36-bit dividend, 32-bit divisor, one quotient bit per step
	localparam int DVD_W     = 36;
	localparam int DVS_W     = 32;
	localparam int DIV_STEPS = DVD_W;
	localparam int DIV_CNT_W = 6;

	// rate and volume scaling
	localparam int RATE_W    = 24;
	localparam int TGT_SHIFT = 18;

	typedef struct packed {
		logic [1:0]  operation;
		logic        pin_level;
		logic [31:0] time_ms;
		logic [15:0] volume;
	} in_word_t;

	typedef struct packed {
		logic [23:0] flow_rate;
		logic [1:0]  rate_class;
		logic        flowing;
		logic        collection_done;
	} out_word_t;

	typedef struct packed {
		logic [19:0] rate_constant;
		logic [7:0]  min_pulses;
		logic [15:0] pulse_timeout_ms;
		logic [23:0] slow_threshold;
		logic [23:0] fast_threshold;
		logic [19:0] pulses_per_gallon;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic eval;
		logic mul_rate;
		logic mul_vol;
		logic div_ld_rate;
		logic div_step;
		logic ring_upd;
		logic avg_upd;
		logic tgt_upd;
		logic check;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       go_rate;
		logic       div_done;
		logic       out_free;
	} sts_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_EVAL,
		S_MUL_RATE,
		S_DIV_RATE_LD,
		S_DIV_RATE,
		S_RING,
		S_AVG,
		S_MUL_VOL,
		S_TARGET,
		S_CHECK,
		S_FINISH
	} state_t;

endpackage

FILE: hw/rtl/pulse_flow_meter_unit.sv
// processing: a sample that yields a new rate runs evaluation, the multiply, the rate
//   division and the ring and average updates; other words take shorter paths
// throughput: one word at a time; the next word is taken at the earliest in the cycle
//   after the result moves to the output register
// reset: asynchronous, clears all control state, config to defaults; ring entries
//   read as zero through per-entry valid bits, so no clearing pass is needed
module pulse_flow_meter_unit #(
	parameter int AVG_DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  pfm_pkg::in_word_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output pfm_pkg::out_word_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pfm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pfm_pkg::CFG_DATA_W-1:0]      cfg_data
);

	pfm_pkg::cfg_t cfg_q;
	pfm_pkg::cmd_t cmd;
	pfm_pkg::sts_t sts;
	logic          in_accept;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_constant     <= pfm_pkg::RST_RATE_CONSTANT;
			cfg_q.min_pulses        <= pfm_pkg::RST_MIN_PULSES;
			cfg_q.pulse_timeout_ms  <= pfm_pkg::RST_PULSE_TIMEOUT;
			cfg_q.slow_threshold    <= pfm_pkg::RST_SLOW_THRESH;
			cfg_q.fast_threshold    <= pfm_pkg::RST_FAST_THRESH;
			cfg_q.pulses_per_gallon <= pfm_pkg::RST_PULSES_PER_GAL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pfm_pkg::REG_RATE_CONSTANT:  cfg_q.rate_constant     <= cfg_data[19:0];
				pfm_pkg::REG_MIN_PULSES:     cfg_q.min_pulses        <= cfg_data[7:0];
				pfm_pkg::REG_PULSE_TIMEOUT:  cfg_q.pulse_timeout_ms  <= cfg_data[15:0];
				pfm_pkg::REG_SLOW_THRESH:    cfg_q.slow_threshold    <= cfg_data[23:0];
				pfm_pkg::REG_FAST_THRESH:    cfg_q.fast_threshold    <= cfg_data[23:0];
				pfm_pkg::REG_PULSES_PER_GAL: cfg_q.pulses_per_gallon <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// controller
	pfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// datapath
	pfm_dp #(
		.AVG_DEPTH (AVG_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_accept),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

FILE: hw/rtl/pfm_ctrl.sv
module pfm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  pfm_pkg::sts_t   sts,
	output pfm_pkg::cmd_t   cmd,
	output logic            in_stall
);

	pfm_pkg::state_t state_q;
	pfm_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfm_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			pfm_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nxt = pfm_pkg::S_DISPATCH;
				end
			end
			pfm_pkg::S_DISPATCH: begin
				case (sts.op)
					pfm_pkg::OP_SAMPLE: state_nxt = pfm_pkg::S_EVAL;
					pfm_pkg::OP_START:  state_nxt = pfm_pkg::S_MUL_VOL;
					pfm_pkg::OP_CHECK:  state_nxt = pfm_pkg::S_CHECK;
					default:            state_nxt = pfm_pkg::S_FINISH;
				endcase
			end
			pfm_pkg::S_EVAL: begin
				cmd.eval  = 1'b1;
				state_nxt = sts.go_rate ? pfm_pkg::S_MUL_RATE : pfm_pkg::S_FINISH;
			end
			pfm_pkg::S_MUL_RATE: begin
				cmd.mul_rate = 1'b1;
				state_nxt    = pfm_pkg::S_DIV_RATE_LD;
			end
			pfm_pkg::S_DIV_RATE_LD: begin
				cmd.div_ld_rate = 1'b1;
				state_nxt       = pfm_pkg::S_DIV_RATE;
			end
			pfm_pkg::S_DIV_RATE: begin
				if (sts.div_done) begin
					state_nxt = pfm_pkg::S_RING;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			pfm_pkg::S_RING: begin
				cmd.ring_upd = 1'b1;
				state_nxt    = pfm_pkg::S_AVG;
			end
			pfm_pkg::S_AVG: begin
				cmd.avg_upd = 1'b1;
				state_nxt   = pfm_pkg::S_FINISH;
			end
			pfm_pkg::S_MUL_VOL: begin
				cmd.mul_vol = 1'b1;
				state_nxt   = pfm_pkg::S_TARGET;
			end
			pfm_pkg::S_TARGET: begin
				cmd.tgt_upd = 1'b1;
				state_nxt   = pfm_pkg::S_FINISH;
			end
			pfm_pkg::S_CHECK: begin
				cmd.check = 1'b1;
				state_nxt = pfm_pkg::S_FINISH;
			end
			pfm_pkg::S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = pfm_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = pfm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/pfm_dp.sv
module pfm_dp #(
	parameter int AVG_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  pfm_pkg::in_word_t  in_data,
	input  pfm_pkg::cfg_t      cfg,
	input  pfm_pkg::cmd_t      cmd,
	output pfm_pkg::sts_t      sts,
	output logic               out_valid,
	input  logic               out_stall,
	output pfm_pkg::out_word_t out_data
);

	localparam int SLOT_W = $clog2(AVG_DEPTH);
	localparam int SUM_W  = pfm_pkg::RATE_W + SLOT_W + 1;
	// floor(sum / AVG_DEPTH) as a multiply by the rounded-up reciprocal and a shift
	localparam int AVG_SHIFT = SUM_W + SLOT_W;
	localparam logic [63:0] AVG_RECIP = ((64'd1 << AVG_SHIFT) + 64'(AVG_DEPTH) - 64'd1)
		/ 64'(AVG_DEPTH);

	// accepted word
	pfm_pkg::in_word_t in_q;

	// sample state
	logic        last_level_q;
	logic [15:0] edge_cnt_q;
	logic [31:0] last_time_q;

	// ring
	logic [23:0]       ring_mem [AVG_DEPTH];
	logic [23:0]       rd_q;
	logic [AVG_DEPTH-1:0] vld_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SUM_W-1:0]  sum_q;
	logic [23:0]       avg_q;

	// collection state
	logic        collecting_q;
	logic [31:0] collected_q;
	logic [31:0] target_q;
	logic        done_q;

	// multiplier and divider
	logic [35:0]              prod_q;
	logic [pfm_pkg::DVD_W-1:0] dvd_q;
	logic [pfm_pkg::DVS_W-1:0] dvs_q;
	logic [pfm_pkg::DVS_W-1:0] rem_q;
	logic [pfm_pkg::DIV_CNT_W-1:0] div_cnt_q;

	// output register
	logic               out_valid_q;
	pfm_pkg::out_word_t out_q;

	// combinational
	logic [15:0] cnt_new;
	logic [31:0] elapsed;
	logic        enough;
	logic        timed_out;
	logic [15:0] mul_a;
	logic [19:0] mul_b;
	logic [pfm_pkg::DVS_W:0] rem_sh;
	logic        rem_ge;
	logic [23:0] rate_sat;
	logic [23:0] old_rate;
	logic [32:0] coll_sum;
	logic        coll_reached;
	logic [1:0]  cls;
	logic [2*SUM_W:0] avg_prod;

	// edge count and timing for the current sample
	always_comb begin
		cnt_new = edge_cnt_q;
		if (last_level_q && !in_q.pin_level && edge_cnt_q != 16'hFFFF) begin
			cnt_new = edge_cnt_q + 16'd1;
		end
		elapsed   = in_q.time_ms - last_time_q;
		enough    = cnt_new >= {8'd0, cfg.min_pulses};
		timed_out = elapsed > {16'd0, cfg.pulse_timeout_ms};
	end

	// shared multiplier operands
	assign mul_a = cmd.mul_vol ? in_q.volume : edge_cnt_q;
	assign mul_b = cmd.mul_vol ? cfg.pulses_per_gallon : cfg.rate_constant;

	// restoring divider step
	assign rem_sh = {rem_q, dvd_q[pfm_pkg::DVD_W-1]};
	assign rem_ge = rem_sh >= {1'b0, dvs_q};

	// rate saturation and the entry being replaced
	assign rate_sat = (|dvd_q[pfm_pkg::DVD_W-1:pfm_pkg::RATE_W]) ? 24'hFFFFFF
		: dvd_q[pfm_pkg::RATE_W-1:0];
	assign old_rate = vld_q[slot_q] ? rd_q : 24'd0;
	assign coll_sum = {1'b0, collected_q} + {17'd0, edge_cnt_q};
	assign coll_reached = collected_q >= target_q;

	// ring average
	assign avg_prod = sum_q * AVG_RECIP[SUM_W:0];

	// rate class
	always_comb begin
		if (avg_q < cfg.slow_threshold) begin
			cls = pfm_pkg::CLASS_SLOW;
		end else if (avg_q > cfg.fast_threshold) begin
			cls = pfm_pkg::CLASS_FAST;
		end else begin
			cls = pfm_pkg::CLASS_OK;
		end
	end

	// ring memory with registered read
	always_ff @(posedge clk) begin
		if (cmd.ring_upd) begin
			ring_mem[slot_q] <= rate_sat;
		end
		rd_q <= ring_mem[slot_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load) begin
			in_q <= in_data;
		end
		if (cmd.mul_rate || cmd.mul_vol) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.eval) begin
			dvs_q <= elapsed;
		end
		if (cmd.div_ld_rate) begin
			dvd_q <= prod_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[pfm_pkg::DVD_W-2:0], rem_ge};
			rem_q <= rem_ge ? pfm_pkg::DVS_W'(rem_sh - {1'b0, dvs_q})
				: rem_sh[pfm_pkg::DVS_W-1:0];
		end
		if (cmd.out_load) begin
			out_q.flow_rate       <= avg_q;
			out_q.rate_class      <= cls;
			out_q.flowing         <= avg_q > cfg.slow_threshold;
			out_q.collection_done <= done_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b1;
			edge_cnt_q   <= '0;
			last_time_q  <= '0;
			vld_q        <= '0;
			slot_q       <= '0;
			sum_q        <= '0;
			avg_q        <= '0;
			collecting_q <= 1'b0;
			collected_q  <= '0;
			target_q     <= '0;
			done_q       <= 1'b0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				done_q <= 1'b0;
			end
			// sample evaluation
			if (cmd.eval) begin
				last_level_q <= in_q.pin_level;
				edge_cnt_q   <= cnt_new;
				if (enough) begin
					last_time_q <= in_q.time_ms;
				end else if (timed_out) begin
					avg_q <= '0;
				end
			end
			// divider step count
			if (cmd.div_ld_rate) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + pfm_pkg::DIV_CNT_W'(1);
			end
			// ring update and pulse hand-off
			if (cmd.ring_upd) begin
				sum_q         <= sum_q + SUM_W'(rate_sat) - SUM_W'(old_rate);
				vld_q[slot_q] <= 1'b1;
				slot_q        <= (slot_q == SLOT_W'(AVG_DEPTH - 1)) ? '0
					: slot_q + SLOT_W'(1);
				if (collecting_q) begin
					collected_q <= coll_sum[32] ? 32'hFFFFFFFF : coll_sum[31:0];
				end
				edge_cnt_q <= '0;
			end
			if (cmd.avg_upd) begin
				avg_q <= avg_prod[AVG_SHIFT +: pfm_pkg::RATE_W];
			end
			// collection
			if (cmd.tgt_upd) begin
				target_q     <= 32'(prod_q >> pfm_pkg::TGT_SHIFT);
				collecting_q <= 1'b1;
			end
			if (cmd.check && coll_reached) begin
				collecting_q <= 1'b0;
				target_q     <= '0;
				collected_q  <= '0;
				done_q       <= 1'b1;
			end
			// output word handshake
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// status to controller
	assign sts.op       = in_q.operation;
	assign sts.go_rate  = enough && (elapsed != 32'd0);
	assign sts.div_done = div_cnt_q == pfm_pkg::DIV_CNT_W'(pfm_pkg::DIV_STEPS);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// divider never runs past its last quotient bit
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> div_cnt_q < pfm_pkg::DIV_CNT_W'(pfm_pkg::DIV_STEPS))
		else $error("divider stepped past its last bit");

	// a waiting word is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output word overwritten while stalled");

	// pulses are handed off once a rate is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ring_upd |=> edge_cnt_q == 16'd0)
		else $error("edge count not cleared after rate update");

	// a completed check ends the collection
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.check && coll_reached) |=> (!collecting_q && done_q))
		else $error("completed check did not end collection");

endmodule
